### rtl/assert_macros.svh
// Assertion macros used by the translator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### rtl/tlbpt_pkg.sv
// Package: default sizes and fixed field widths of the page table translator.
package tlbpt_pkg;

    localparam int ADDR_W           = 16;
    localparam int CNT_W            = 16;
    localparam int OFFSET_WIDTH_DEF = 8;
    localparam int PAGE_ENTRIES_DEF = 256;
    localparam int TLB_ENTRIES_DEF  = 16;

endpackage

### rtl/tlbpt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/tlb_page_table_translator.sv
// Top level: demand-paging translator, page table in RAM, TLB residency by fault age.
// When the page count is a power of two (or covers every page number), the page table
// is read as the request is taken; otherwise an S_MOD state first reduces the page
// number using a quotient from reciprocal multiply. One request at a time,
// set by the page table read-modify-write. After reset a clearing pass invalidates
// the page table; no request is taken until it ends.
module tlb_page_table_translator #(
    parameter int OFFSET_WIDTH = tlbpt_pkg::OFFSET_WIDTH_DEF,
    parameter int PAGE_ENTRIES = tlbpt_pkg::PAGE_ENTRIES_DEF,
    parameter int TLB_ENTRIES  = tlbpt_pkg::TLB_ENTRIES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [tlbpt_pkg::ADDR_W-1:0] virt_addr,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [tlbpt_pkg::ADDR_W-1:0] phys_addr,
    output logic                         tlb_hit_flag,
    output logic                         fault_flag,
    output logic [tlbpt_pkg::CNT_W-1:0]  fault_total,
    output logic [tlbpt_pkg::CNT_W-1:0]  hit_total
);

    import tlbpt_pkg::*;

    `include "assert_macros.svh"

    localparam int PAGE_W  = ADDR_W - OFFSET_WIDTH;
    localparam int IDX_W   = $clog2(PAGE_ENTRIES);
    localparam int NF_W    = $clog2(PAGE_ENTRIES + 1);
    localparam int WORD_W  = IDX_W + 1;
    localparam int SHIFT_S = PAGE_W + IDX_W;
    localparam int RCP_W   = PAGE_W + 2;
    localparam int PROD_W  = PAGE_W + RCP_W;
    localparam bit POW2    = (PAGE_ENTRIES & (PAGE_ENTRIES - 1)) == 0;
    localparam bit DIRECT  = POW2 || (PAGE_ENTRIES >= (1 << PAGE_W));
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(PAGE_ENTRIES - 1);
    localparam logic [RCP_W-1:0]  RECIP    =
        RCP_W'(((1 << SHIFT_S) + PAGE_ENTRIES - 1) / PAGE_ENTRIES);
    localparam logic [PAGE_W-1:0] DIV_N    = PAGE_W'(PAGE_ENTRIES);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_MOD, S_EXEC} state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    clr_idx_reg, clr_idx_next;
    logic [ADDR_W-1:0]   va_reg, va_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [PAGE_W-1:0]   quo_reg, quo_next;
    logic [PAGE_W-1:0]   shf_reg, shf_next;
    logic [NF_W-1:0]     next_frame_reg, next_frame_next;
    logic [CNT_W-1:0]    fault_cnt_reg, fault_cnt_next;
    logic [CNT_W-1:0]    hit_cnt_reg, hit_cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]   phys_reg, phys_next;
    logic                hit_flag_reg, hit_flag_next;
    logic                fault_flag_reg, fault_flag_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    logic [PAGE_W-1:0]            page_in;
    logic [PROD_W-1:0]            recip_prod;
    logic [PAGE_W-1:0]            quo_calc;
    logic [IDX_W-1:0]             mod_idx;
    logic                         entry_valid;
    logic [IDX_W-1:0]             entry_frame;
    logic [IDX_W-1:0]             frame_sel;
    logic [NF_W-1:0]              age;
    logic                         tlb_hit;
    logic [IDX_W+OFFSET_WIDTH-1:0] pa_cat;
    logic                         in_fire;
    logic                         exec_fire;
    logic                         fault_fire;

    tlbpt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PAGE_ENTRIES)
    ) u_page_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign page_in    = virt_addr[ADDR_W-1:OFFSET_WIDTH];
    // quotient by reciprocal multiply, exact for every page number
    assign recip_prod = PROD_W'(page_in) * PROD_W'(RECIP);
    assign quo_calc   = PAGE_W'(recip_prod >> SHIFT_S);
    assign mod_idx    = IDX_W'(shf_reg - quo_reg * DIV_N);

    assign entry_valid = ram_rdata[IDX_W];
    assign entry_frame = ram_rdata[IDX_W-1:0];
    assign frame_sel   = entry_valid ? entry_frame : next_frame_reg[IDX_W-1:0];
    // frames are handed out in fault order, so the TLB holds the newest TLB_ENTRIES frames
    assign age         = next_frame_reg - NF_W'(entry_frame);
    assign tlb_hit     = entry_valid && (32'(age) <= 32'(TLB_ENTRIES));
    assign pa_cat      = {frame_sel, va_reg[OFFSET_WIDTH-1:0]};

    assign in_stall   = (state_reg != S_IDLE);
    assign in_fire    = in_valid && !in_stall;
    assign exec_fire  = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);
    assign fault_fire = exec_fire && !entry_valid;

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        va_next         = va_reg;
        idx_next        = idx_reg;
        quo_next        = quo_reg;
        shf_next        = shf_reg;
        next_frame_next = next_frame_reg;
        fault_cnt_next  = fault_cnt_reg;
        hit_cnt_next    = hit_cnt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        phys_next       = phys_reg;
        hit_flag_next   = hit_flag_reg;
        fault_flag_next = fault_flag_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = {1'b1, next_frame_reg[IDX_W-1:0]};
        ram_re          = 1'b0;
        ram_raddr       = IDX_W'(page_in);

        case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_idx_reg;
                ram_wdata    = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    va_next = virt_addr;
                    if (DIRECT)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = IDX_W'(page_in);
                        idx_next   = IDX_W'(page_in);
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        shf_next   = page_in;
                        quo_next   = quo_calc;
                        state_next = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = mod_idx;
                idx_next   = mod_idx;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    out_valid_next  = 1'b1;
                    phys_next       = ADDR_W'(pa_cat);
                    fault_flag_next = !entry_valid;
                    hit_flag_next   = tlb_hit;
                    if (!entry_valid)
                    begin
                        ram_we          = 1'b1;
                        next_frame_next = next_frame_reg + 1'b1;
                        fault_cnt_next  = (fault_cnt_reg == '1) ? fault_cnt_reg
                                                                : fault_cnt_reg + 1'b1;
                    end
                    else if (tlb_hit)
                    begin
                        hit_cnt_next = (hit_cnt_reg == '1) ? hit_cnt_reg : hit_cnt_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            va_reg         <= '0;
            idx_reg        <= '0;
            quo_reg        <= '0;
            shf_reg        <= '0;
            next_frame_reg <= '0;
            fault_cnt_reg  <= '0;
            hit_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            phys_reg       <= '0;
            hit_flag_reg   <= 1'b0;
            fault_flag_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            va_reg         <= va_next;
            idx_reg        <= idx_next;
            quo_reg        <= quo_next;
            shf_reg        <= shf_next;
            next_frame_reg <= next_frame_next;
            fault_cnt_reg  <= fault_cnt_next;
            hit_cnt_reg    <= hit_cnt_next;
            out_valid_reg  <= out_valid_next;
            phys_reg       <= phys_next;
            hit_flag_reg   <= hit_flag_next;
            fault_flag_reg <= fault_flag_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign phys_addr    = phys_reg;
    assign tlb_hit_flag = hit_flag_reg;
    assign fault_flag   = fault_flag_reg;
    assign fault_total  = fault_cnt_reg;
    assign hit_total    = hit_cnt_reg;

    `ASSERT_NEVER(a_hit_and_fault, out_valid_reg && hit_flag_reg && fault_flag_reg, "both flags")
    `ASSERT_NEVER(a_frame_bound, 32'(next_frame_reg) > 32'(PAGE_ENTRIES), "frame overflow")
    `ASSERT_CLK(a_frame_on_fault, $changed(next_frame_reg) |-> $past(fault_fire), "stray frame")
    `ASSERT_CLK(a_result_from_exec, $rose(out_valid_reg) |-> $past(exec_fire), "stray result")

endmodule
